// ===== hdl/eptn_pkg.sv =====
// Shared types, constants and degree tables for the epoch prefetch depth tuner.
`default_nettype none

package eptn_pkg;

  localparam int NUM_CONFIGS_DEF = 14;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CNT_W     = 24;
  localparam int CYC_W     = 64;
  localparam int CFG_W     = 4;
  localparam int DEG_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_MAX             = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] EXPLORE_LEN_RESET   = CNT_W'(1000);
  localparam logic [CNT_W-1:0] EXPLOIT_LEN_RESET   = CNT_W'(100000);
  localparam logic [CYC_W-1:0] CYC_MAX             = {CYC_W{1'b1}};

  localparam logic [CFG_W-1:0] CFG_DEFAULT = CFG_W'(0);
  localparam logic [CFG_W-1:0] STRIDE_LO   = CFG_W'(8);
  localparam logic [CFG_W-1:0] STRIDE_HI   = CFG_W'(13);
  localparam logic [DEG_W-1:0] STRIDE_DEG  = DEG_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPLORE_LEN = 1'b0,
    REG_EXPLOIT_LEN = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACC_PLAIN,
    ACC_ENTER,
    ACC_STEP,
    ACC_FINISH
  } acc_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_CMP
  } bk_state_t;

  typedef struct packed {
    logic                 we;
    cfg_reg_t             idx;
    logic [CNT_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    acc_kind_t            kind;
    logic [CFG_W-1:0]     trial;
    logic [CYC_W-1:0]     now;
  } acc_beat_t;

  typedef struct packed {
    logic                 explore;
    logic [CFG_W-1:0]     cfg;
  } res_beat_t;

  function automatic logic [DEG_W-1:0] stream_deg(input logic [CFG_W-1:0] c);
    logic [DEG_W-1:0] d;
    unique case (c) inside
      4'd1:        d = DEG_W'(0);
      4'd2, 4'd8:  d = DEG_W'(2);
      4'd3, 4'd9:  d = DEG_W'(3);
      4'd4, 4'd10: d = DEG_W'(4);
      4'd5, 4'd11: d = DEG_W'(5);
      4'd6, 4'd12: d = DEG_W'(6);
      4'd7, 4'd13: d = DEG_W'(7);
      default:     d = DEG_W'(5);
    endcase
    return d;
  endfunction

  function automatic logic [DEG_W-1:0] stride_deg(input logic [CFG_W-1:0] c);
    logic [DEG_W-1:0] d;
    d = (c >= STRIDE_LO && c <= STRIDE_HI) ? STRIDE_DEG : DEG_W'(0);
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/eptn_fifo.sv =====
// Small register FIFO used for the access queue and the result queue.
`default_nettype none

module eptn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r,  cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == CW'(0));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? AW'(0) : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? AW'(0) : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/eptn_front.sv =====
// Front end: epoch length registers, access counting and classification of each access.
`default_nettype none

module eptn_front #(
  parameter int NUM_CONFIGS = eptn_pkg::NUM_CONFIGS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire eptn_pkg::cfg_wr_t           cfg,
  input  wire logic                        in_push,
  input  wire logic [eptn_pkg::CYC_W-1:0]  in_cycle_now,
  input  wire logic                        q_full,
  output logic                             q_push,
  output eptn_pkg::acc_beat_t              q_data
);
  import eptn_pkg::*;

  localparam logic [CFG_W-1:0] TRIAL_LAST = CFG_W'(NUM_CONFIGS - 1);

  logic [CNT_W-1:0] explore_len_r;
  logic [CNT_W-1:0] exploit_len_r;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic             mode_r,  mode_nxt;
  logic [CFG_W-1:0] trial_r, trial_nxt;
  logic [CNT_W-1:0] cnt_inc;
  acc_kind_t        kind;

  assign q_push  = in_push && !q_full;
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);

  always_comb begin
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    trial_nxt = trial_r;
    kind      = ACC_PLAIN;
    if (q_push) begin
      cnt_nxt = cnt_inc;
      if (!mode_r) begin
        if (cnt_inc >= exploit_len_r) begin
          kind      = ACC_ENTER;
          mode_nxt  = 1'b1;
          trial_nxt = CFG_DEFAULT;
          cnt_nxt   = '0;
        end
      end else if (cnt_inc >= explore_len_r) begin
        cnt_nxt = '0;
        if (trial_r >= TRIAL_LAST) begin
          kind     = ACC_FINISH;
          mode_nxt = 1'b0;
        end else begin
          kind      = ACC_STEP;
          trial_nxt = trial_r + CFG_W'(1);
        end
      end
    end
  end

  always_comb begin
    q_data.kind  = kind;
    q_data.trial = trial_r;
    q_data.now   = in_cycle_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      explore_len_r <= EXPLORE_LEN_RESET;
      exploit_len_r <= EXPLOIT_LEN_RESET;
      cnt_r         <= '0;
      mode_r        <= 1'b0;
      trial_r       <= CFG_DEFAULT;
    end else begin
      cnt_r   <= cnt_nxt;
      mode_r  <= mode_nxt;
      trial_r <= trial_nxt;
      if (cfg.we) begin
        unique case (cfg.idx)
          REG_EXPLORE_LEN: explore_len_r <= cfg.data;
          REG_EXPLOIT_LEN: exploit_len_r <= cfg.data;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/eptn_back.sv =====
// Back end: trial timing, running best configuration and result generation.
`default_nettype none

module eptn_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  wire eptn_pkg::acc_beat_t  q_data,
  output logic                      q_pop,
  input  wire logic                 r_full,
  output logic                      r_push,
  output eptn_pkg::res_beat_t       r_data
);
  import eptn_pkg::*;

  bk_state_t        state_r,    state_nxt;
  logic [CYC_W-1:0] start_r,    start_nxt;
  logic [CYC_W-1:0] best_r,     best_nxt;
  logic [CFG_W-1:0] best_idx_r, best_idx_nxt;
  logic [CFG_W-1:0] cfg_r,      cfg_nxt;
  logic             mode_r,     mode_nxt;
  logic [CYC_W-1:0] elapsed_r,  elapsed_nxt;
  acc_kind_t        kind_r,     kind_nxt;
  logic [CFG_W-1:0] trial_r,    trial_nxt;
  logic             take_best;

  // Records arrive once per configuration in index order, so a running minimum
  // with "<=" gives the same winner as a full search, ties to the later index.
  assign take_best = (elapsed_r <= best_r);

  always_comb begin
    state_nxt    = state_r;
    start_nxt    = start_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    cfg_nxt      = cfg_r;
    mode_nxt     = mode_r;
    elapsed_nxt  = elapsed_r;
    kind_nxt     = kind_r;
    trial_nxt    = trial_r;
    q_pop        = 1'b0;
    r_push       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty && !r_full) begin
          q_pop = 1'b1;
          unique case (q_data.kind)
            ACC_ENTER: begin
              mode_nxt     = 1'b1;
              cfg_nxt      = CFG_DEFAULT;
              start_nxt    = q_data.now;
              best_nxt     = CYC_MAX;
              best_idx_nxt = CFG_DEFAULT;
              r_push       = 1'b1;
            end
            ACC_STEP, ACC_FINISH: begin
              elapsed_nxt = q_data.now - start_r;
              start_nxt   = q_data.now;
              kind_nxt    = q_data.kind;
              trial_nxt   = q_data.trial;
              state_nxt   = BK_CMP;
            end
            default: begin
              r_push = 1'b1;
            end
          endcase
        end
      end
      BK_CMP: begin
        r_push    = 1'b1;
        state_nxt = BK_IDLE;
        if (take_best) begin
          best_nxt     = elapsed_r;
          best_idx_nxt = trial_r;
        end
        if (kind_r == ACC_FINISH) begin
          mode_nxt = 1'b0;
          cfg_nxt  = take_best ? trial_r : best_idx_r;
        end else begin
          cfg_nxt = trial_r + CFG_W'(1);
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    r_data.explore = mode_nxt;
    r_data.cfg     = cfg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      start_r    <= '0;
      best_r     <= CYC_MAX;
      best_idx_r <= CFG_DEFAULT;
      cfg_r      <= CFG_DEFAULT;
      mode_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      start_r    <= start_nxt;
      best_r     <= best_nxt;
      best_idx_r <= best_idx_nxt;
      cfg_r      <= cfg_nxt;
      mode_r     <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    kind_r    <= kind_nxt;
    trial_r   <= trial_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/epoch_prefetch_depth_tuner.sv =====
// Top level of the epoch prefetch depth tuner: front end, access queue, back end, result queue.
//
//   channel  direction  beat                                handshake
//   in_      input      cycle_now                           push / full
//   out_     output     mode, config, stream/stride degree  empty / pop
//   cfg_     input      epoch length register write         we, no wait
//
// The front end takes one access beat per cycle while full is low and writes it,
// already classified, into a two-entry queue. The back end drains a beat in its
// idle state; when a trial ends it does the elapsed-cycle subtract in the idle
// state and the best-so-far compare in the compare state, taking no new beat
// there, so the sustained rate is one beat per cycle outside trial boundaries
// while the result queue has room. Results wait in a two-entry queue, so a
// stalled pop holds results without stopping the input side until both queues
// fill. Reset is synchronous; there is no clearing pass.
`default_nettype none

module epoch_prefetch_depth_tuner #(
  parameter int NUM_CONFIGS = eptn_pkg::NUM_CONFIGS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [eptn_pkg::CYC_W-1:0]      in_cycle_now,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic                                 out_explore_mode,
  output logic [eptn_pkg::CFG_W-1:0]           out_config_index,
  output logic [eptn_pkg::DEG_W-1:0]           out_streamer_degree,
  output logic [eptn_pkg::DEG_W-1:0]           out_stride_degree,
  input  wire logic                            cfg_we,
  input  wire logic [eptn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [eptn_pkg::CNT_W-1:0]      cfg_wdata
);
  import eptn_pkg::*;

  cfg_wr_t   cfg;
  acc_beat_t fq_wdata, fq_rdata;
  logic      fq_push, fq_full, fq_pop, fq_empty;
  res_beat_t rq_wdata, rq_rdata;
  logic      rq_push, rq_full;

  // The write port is gathered into one struct for the front end.
  always_comb begin
    cfg.we   = cfg_we;
    cfg.idx  = cfg_reg_t'(cfg_index);
    cfg.data = cfg_wdata;
  end

  assign in_full = fq_full;

  eptn_front #(
    .NUM_CONFIGS (NUM_CONFIGS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_push      (in_push),
    .in_cycle_now (in_cycle_now),
    .q_full       (fq_full),
    .q_push       (fq_push),
    .q_data       (fq_wdata)
  );

  // Access queue between the classifier and the back end.
  eptn_fifo #(
    .WIDTH ($bits(acc_beat_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_acc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  eptn_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (fq_empty),
    .q_data  (fq_rdata),
    .q_pop   (fq_pop),
    .r_full  (rq_full),
    .r_push  (rq_push),
    .r_data  (rq_wdata)
  );

  // Result queue; the head entry drives the result ports.
  eptn_fifo #(
    .WIDTH ($bits(res_beat_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  // Degrees are decoded from the queued configuration at the output.
  assign out_explore_mode    = rq_rdata.explore;
  assign out_config_index    = rq_rdata.cfg;
  assign out_streamer_degree = stream_deg(rq_rdata.cfg);
  assign out_stride_degree   = stride_deg(rq_rdata.cfg);

endmodule

`default_nettype wire

// ===== hdl/eptn_checker.sv =====
// Port-level checks for the epoch prefetch depth tuner and their bind.
`default_nettype none

module eptn_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic       out_explore_mode,
  input wire logic [3:0] out_config_index,
  input wire logic [2:0] out_streamer_degree,
  input wire logic [2:0] out_stride_degree
);

  // No result is left over from before a reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A waiting result beat stays put until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_config_index) && $stable(out_explore_mode)))
    else $error("waiting result changed without a pop");

  // Stride prefetching is on exactly for the stride configurations.
  a_stride: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |->
      ((out_stride_degree != 3'd0) ==
       (out_config_index >= 4'd8 && out_config_index <= 4'd13)))
    else $error("stride degree does not match configuration");

  // The off configuration has no stream prefetching.
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_config_index == 4'd1) |-> (out_streamer_degree == 3'd0))
    else $error("off configuration shows a stream degree");

endmodule

bind epoch_prefetch_depth_tuner eptn_checker u_eptn_checker (.*);

`default_nettype wire
